FILE: design/lpr_pkg.sv
`default_nettype none
package lpr_pkg;

  localparam int RING_BYTES_DEFAULT = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEADER,
    ST_BYTES
  } state_t;

endpackage
`default_nettype wire

FILE: design/lpr_ring_mem.sv
`default_nettype none
module lpr_ring_mem #(
  parameter int DEPTH = lpr_pkg::RING_BYTES_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/lpr_ctrl.sv
`default_nettype none
module lpr_ctrl #(
  parameter int RING_BYTES = lpr_pkg::RING_BYTES_DEFAULT,
  parameter int IW         = $clog2(RING_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,
  input  wire logic          s_axis_tlast,
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic      [7:0]    m_axis_tdata,
  output logic               m_axis_tlast,
  output logic      [2:0]    m_axis_tuser,
  output logic               wr_en,
  output logic      [IW-1:0] wr_addr,
  output logic      [7:0]    wr_data,
  output logic               rd_en,
  output logic      [IW-1:0] rd_addr,
  input  wire logic [7:0]    rd_data
);

  localparam int CW = IW + 1;
  localparam logic [CW-1:0] N_C = CW'(RING_BYTES);

  function automatic logic [IW-1:0] wrap(input logic [CW-1:0] sum);
    logic [CW-1:0] s;
    s = (sum >= N_C) ? sum - N_C : sum;
    return s[IW-1:0];
  endfunction

  lpr_pkg::state_t state, state_next;
  logic [IW-1:0] rp, rp_next;
  logic [IW-1:0] wp, wp_next;
  logic [CW-1:0] pending_count, pending_count_next;
  logic          pending_overflow, pending_overflow_next;
  logic [CW-1:0] remain, remain_next;

  logic          out_valid;
  logic [7:0]    out_data;
  logic          out_last;
  logic [2:0]    out_user;
  logic          out_load;
  logic [7:0]    load_data;
  logic          load_last;
  logic [2:0]    load_user;

  logic          out_space;
  logic          accept;
  logic [CW-1:0] filled_bytes;
  logic [CW-1:0] free_bytes;
  logic [CW-1:0] size;
  logic          reject;

  assign out_space     = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == lpr_pkg::ST_IDLE) && out_space;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign filled_bytes  = (wp >= rp) ? CW'(wp) - CW'(rp) : CW'(wp) + N_C - CW'(rp);
  assign free_bytes    = N_C - CW'(1) - filled_bytes;
  assign size          = pending_count + CW'(1);
  assign reject        = pending_overflow || (size > free_bytes);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_user;

  always_comb begin
    state_next            = state;
    rp_next               = rp;
    wp_next               = wp;
    pending_count_next    = pending_count;
    pending_overflow_next = pending_overflow;
    remain_next           = remain;
    out_load              = 1'b0;
    load_data             = '0;
    load_last             = 1'b1;
    load_user             = '0;
    wr_en                 = 1'b0;
    wr_addr               = wp;
    wr_data               = s_axis_tdata;
    rd_en                 = 1'b0;
    rd_addr               = rp;
    unique case (state)
      lpr_pkg::ST_IDLE: begin
        if (accept) begin
          if (!s_axis_tuser[0]) begin
            if (!s_axis_tlast) begin
              if (!pending_overflow) begin
                if ((pending_count + CW'(2)) <= free_bytes) begin
                  wr_en              = 1'b1;
                  wr_addr            = wrap(CW'(wp) + size);
                  pending_count_next = size;
                end else begin
                  pending_overflow_next = 1'b1;
                end
              end
            end else begin
              out_load  = 1'b1;
              load_user = {reject, 2'b00};
              if (!reject) begin
                wr_en   = 1'b1;
                wr_addr = wp;
                wr_data = 8'(size);
                wp_next = wrap(CW'(wp) + size);
              end
              pending_count_next    = '0;
              pending_overflow_next = 1'b0;
            end
          end else begin
            if ((rp == wp) || s_axis_tuser[1]) begin
              out_load  = 1'b1;
              load_user = 3'b010;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = rp;
              state_next = lpr_pkg::ST_HEADER;
            end
          end
        end
      end
      lpr_pkg::ST_HEADER: begin
        if (out_space) begin
          if ((rd_data == 8'd0) || (rd_data > 8'(filled_bytes))) begin
            rp_next    = wp;
            out_load   = 1'b1;
            load_user  = 3'b010;
            state_next = lpr_pkg::ST_IDLE;
          end else if (rd_data == 8'd1) begin
            rp_next    = wrap(CW'(rp) + CW'(1));
            out_load   = 1'b1;
            state_next = lpr_pkg::ST_IDLE;
          end else begin
            rp_next     = wrap(CW'(rp) + CW'(1));
            remain_next = CW'(rd_data - 8'd1);
            rd_en       = 1'b1;
            rd_addr     = rp_next;
            state_next  = lpr_pkg::ST_BYTES;
          end
        end
      end
      lpr_pkg::ST_BYTES: begin
        if (out_space) begin
          out_load    = 1'b1;
          load_data   = rd_data;
          load_last   = (remain == CW'(1));
          load_user   = 3'b001;
          rp_next     = wrap(CW'(rp) + CW'(1));
          remain_next = remain - CW'(1);
          if (remain == CW'(1)) begin
            state_next = lpr_pkg::ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rp_next;
          end
        end
      end
      default: begin
        state_next = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp               <= '0;
      wp               <= '0;
      pending_count    <= '0;
      pending_overflow <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      rp               <= rp_next;
      wp               <= wp_next;
      pending_count    <= pending_count_next;
      pending_overflow <= pending_overflow_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    remain <= remain_next;
    if (out_load) begin
      out_data <= load_data;
      out_last <= load_last;
      out_user <= load_user;
    end
  end

  a_pointers_in_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(rp) < N_C) && (CW'(wp) < N_C))
    else $error("ring pointer outside the ring");

  a_pending_fits: assert property (@(posedge clk) disable iff (rst)
    (!pending_overflow && (pending_count != '0)) |-> (size <= free_bytes))
    else $error("pending string larger than the free space");

  a_bytes_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == lpr_pkg::ST_BYTES) |-> (remain != '0))
    else $error("byte streaming with no bytes left");

  a_stall_holds_read: assert property (@(posedge clk) disable iff (rst)
    ((state == lpr_pkg::ST_BYTES) && !out_space) |=> $stable(rd_data) && $stable(rp))
    else $error("read data lost during a stall");

endmodule
`default_nettype wire

FILE: design/length_prefixed_packet_ring.sv
// Length-prefixed packet ring.
// Input channel s_axis: tuser[0] is the command (0 push, 1 pop), tuser[1] says
// the sink is busy, tdata is a string byte and tlast marks the terminator of a push.
// Push bytes are stored behind the write pointer; the terminator writes the length
// header and commits the string, or drops it and reports a rejection.
// Output channel m_axis: tdata is a popped byte, tlast marks the last result of the
// input transaction, and tuser carries has_byte, nothing_popped and push_rejected.
// A push byte gives no result. A terminator or a refused pop gives one result in the
// next cycle. A pop of a string of L bytes first reads the header from the ring
// memory, then streams one byte per cycle while the receiver does not stall, through
// its single registered read port.
// While a pop streams, no new input transaction is accepted.
// When the receiver stalls, the result register holds and streaming pauses.
// Reset empties the ring and clears any pending string at once.
`default_nettype none
module length_prefixed_packet_ring #(
  parameter int RING_BYTES = lpr_pkg::RING_BYTES_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // data
  input  wire logic       s_axis_tlast,   // end_of_string
  input  wire logic [1:0] s_axis_tuser,   // cmd, sink_busy
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // out_byte
  output logic            m_axis_tlast,   // last
  output logic      [2:0] m_axis_tuser    // has_byte, nothing_popped, push_rejected
);

  localparam int IW = $clog2(RING_BYTES);

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data;

  lpr_ctrl #(
    .RING_BYTES (RING_BYTES),
    .IW         (IW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

  lpr_ring_mem #(
    .DEPTH (RING_BYTES),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int RING = lpr_pkg::RING_BYTES_DEFAULT;
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] out_byte;
    logic has_byte;
    logic last;
    logic nothing_popped;
    logic push_rejected;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [2:0] m_axis_tuser;

  logic [7:0] ring_copy [RING];
  int copy_head = 0;
  int copy_tail = 0;
  int open_len = 0;
  logic open_dropped = 1'b0;

  ring_result_t awaited_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int strings_committed = 0;
  int strings_rejected = 0;
  int bytes_popped = 0;
  int mismatches = 0;

  length_prefixed_packet_ring uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic note_mismatch(input string what, input ring_result_t want,
                               input ring_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte=%h has=%b last=%b none=%b rej=%b,",
               $realtime, what, want.out_byte, want.has_byte, want.last,
               want.nothing_popped, want.push_rejected);
      $display("    actual byte=%h has=%b last=%b none=%b rej=%b",
               got.out_byte, got.has_byte, got.last, got.nothing_popped,
               got.push_rejected);
    end
  endtask

  always @(posedge clk) begin : check_results
    ring_result_t got;
    ring_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1], m_axis_tuser[2]};
      results_seen++;
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
            got.last !== want.last || got.nothing_popped !== want.nothing_popped ||
            got.push_rejected !== want.push_rejected) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Mirrors the ring for one accepted transaction and queues the results it causes.
  task automatic predict_ring(input logic cmd, input logic [7:0] data, input logic eos,
                              input logic busy);
    int filled;
    int free_space;
    int hdr;
    logic reject;
    filled = (copy_tail + RING - copy_head) % RING;
    free_space = RING - 1 - filled;
    if (cmd == CMD_PUSH) begin
      if (!eos) begin
        if (!open_dropped) begin
          if (open_len + 2 <= free_space) begin
            ring_copy[(copy_tail + 1 + open_len) % RING] = data;
            open_len++;
          end else begin
            open_dropped = 1'b1;
          end
        end
      end else begin
        reject = open_dropped || (open_len + 1 > free_space);
        if (!reject) begin
          ring_copy[copy_tail] = 8'(open_len + 1);
          copy_tail = (copy_tail + open_len + 1) % RING;
          strings_committed++;
        end else begin
          strings_rejected++;
        end
        open_len = 0;
        open_dropped = 1'b0;
        awaited_results.push_back('{8'h00, 1'b0, 1'b1, 1'b0, reject});
      end
    end else if (filled == 0 || busy) begin
      awaited_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 1'b0});
    end else begin
      hdr = ring_copy[copy_head];
      if (hdr == 0 || hdr > filled) begin
        copy_head = copy_tail;
        awaited_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 1'b0});
      end else if (hdr == 1) begin
        copy_head = (copy_head + 1) % RING;
        awaited_results.push_back('{8'h00, 1'b0, 1'b1, 1'b0, 1'b0});
      end else begin
        for (int i = 0; i < hdr - 1; i++) begin
          awaited_results.push_back('{ring_copy[(copy_head + 1 + i) % RING], 1'b1,
                                      (i == hdr - 2), 1'b0, 1'b0});
          bytes_popped++;
        end
        copy_head = (copy_head + hdr) % RING;
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] data, input logic eos,
                           input logic busy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tlast <= eos;
    s_axis_tuser <= {busy, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    predict_ring(cmd, data, eos, busy);
  endtask

  task automatic wait_drained(input int extra);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_item(CMD_POP, 8'h00, 1'b0, 1'b0);
    send_item(CMD_POP, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_PUSH, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_POP, 8'h00, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'h00, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'hFF, 1'b0, 1'b1);
    send_item(CMD_PUSH, 8'h00, 1'b1, 1'b0);
    send_item(CMD_POP, 8'h00, 1'b0, 1'b1);
    send_item(CMD_POP, 8'hFF, 1'b1, 1'b0);
    send_item(CMD_PUSH, 8'h5A, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'h00, 1'b1, 1'b0);
    send_item(CMD_PUSH, 8'h3C, 1'b0, 1'b0);
    send_item(CMD_POP, 8'h00, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'hC3, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'h00, 1'b1, 1'b0);
    send_item(CMD_POP, 8'h00, 1'b0, 1'b0);
    send_item(CMD_POP, 8'h00, 1'b0, 1'b0);
    wait_drained(4);
  endtask

  // Fills the ring to its last free slot, then checks both ways a string is refused.
  task automatic test_full_ring();
    send_item(CMD_PUSH, 8'h00, 1'b0, 1'b0);
    for (int i = 1; i < RING - 3; i++) begin
      send_item(CMD_PUSH, 8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
    end
    send_item(CMD_PUSH, 8'hFF, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'h00, 1'b1, 1'b0);
    send_item(CMD_PUSH, 8'h00, 1'b1, 1'b0);
    send_item(CMD_PUSH, 8'h77, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'h88, 1'b0, 1'b0);
    send_item(CMD_POP, 8'h00, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'h99, 1'b0, 1'b0);
    send_item(CMD_PUSH, 8'h00, 1'b1, 1'b0);
    send_item(CMD_POP, 8'h00, 1'b0, 1'b0);
    wait_drained(4);
  endtask

  task automatic test_random_traffic(input int count, input int idle, input int stall);
    int start;
    int pick;
    int len;
    start = items_sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = ($urandom_range(99) < 15) ? $urandom_range(62, 20) : $urandom_range(6);
        for (int i = 0; i < len; i++) begin
          send_item(CMD_PUSH, 8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
          if ($urandom_range(99) < 5) begin
            send_item(CMD_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
          end
        end
        if ($urandom_range(99) < 95) begin
          send_item(CMD_PUSH, 8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)));
        end
      end else if (pick < 88) begin
        send_item(CMD_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(99) < 15));
      end else begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
    wait_drained(4);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_full_ring();
    test_random_traffic(65, 0, 0);
    test_random_traffic(65, 84, 0);
    test_random_traffic(65, 0, 84);
    test_random_traffic(65, 15, 15);
    wait_drained(DRAIN_CYCLES);
    $display("Sent %0d input transactions and checked %0d result transactions.",
             items_sent, results_seen);
    $display("Strings committed %0d, rejected %0d, bytes popped %0d, mismatches %0d.",
             strings_committed, strings_rejected, bytes_popped, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
